// ----- design/ssd_pkg.sv -----
// Shared types and constants for the SYN scan detector.
// No dependencies; used by ssd_req_ram and syn_scan_detector_core.
package ssd_pkg;

    localparam int PAIR_SLOTS  = 16;
    localparam int REQ_SLOTS   = 64;
    localparam int MAX_RESULTS = 16;
    localparam int PAIR_W      = $clog2(PAIR_SLOTS);
    localparam int REQ_W       = $clog2(REQ_SLOTS);
    localparam int PCNT_W      = $clog2(PAIR_SLOTS + 1);
    localparam int RCNT_W      = $clog2(REQ_SLOTS + 1);
    localparam int NRES_W      = $clog2(MAX_RESULTS + 1);
    localparam int CNT_W       = 7;
    localparam logic [3:0] RATIO_RESET = 4'd3;

    // One request entry as stored in the request memory.
    typedef struct packed {
        logic [PAIR_W-1:0] owner;
        logic [31:0]       ports;
        logic [31:0]       seq;
        logic              answered;
    } t_req_word;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PSCAN,
        ST_RSCAN,
        ST_WRITE,
        ST_RSEL,
        ST_REVAL,
        ST_RFIN
    } t_state;

endpackage

// ----- design/syn_scan_detector_core.sv -----
// SYN versus SYN/ACK port scan detector, top level with its sequencer.
// Depends on ssd_pkg and ssd_req_ram.
// A packet that is not a SYN leaves the sequencer idle; a SYN packet goes through the one-entry-per-cycle
// scans of the pair table and then the request memory, and ends with a write step.
// A report scans the pair table and request memory per stored pair, then the pair table again.
// Each result word is held for one cycle under o_valid and cannot be stalled; reset is
// synchronous, clears all valid bits and the overflow flag, and sets the ratio to 3.
module syn_scan_detector_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_command,
    input  logic [31:0] i_src_addr,
    input  logic [31:0] i_dst_addr,
    input  logic [15:0] i_src_port,
    input  logic [15:0] i_dst_port,
    input  logic [31:0] i_seq_num,
    input  logic [31:0] i_ack_num,
    input  logic        i_syn_flag,
    input  logic        i_ack_flag,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [3:0]  i_cfg_warning_ratio,
    output logic        o_valid,
    output logic [31:0] o_pair_src,
    output logic [31:0] o_pair_dst,
    output logic [6:0]  o_unanswered_count,
    output logic [6:0]  o_answered_count,
    output logic        o_none_flagged,
    output logic        o_table_overflow,
    output logic        o_last
);

    ssd_pkg::t_state r_state, n_state;

    logic [3:0]  r_ratio;
    logic        r_rep;
    logic        r_ovf;
    logic [63:0] r_key;
    logic [31:0] r_ports;
    logic [31:0] r_seq;
    logic        r_is_ack;

    logic [ssd_pkg::PAIR_SLOTS-1:0] r_pair_valid;
    logic [63:0] r_pair_key [ssd_pkg::PAIR_SLOTS];
    logic [ssd_pkg::REQ_SLOTS-1:0] r_req_valid;

    logic [ssd_pkg::RCNT_W-1:0] r_cnt;

    // Packet search results.
    logic                      r_pfound, r_pfree_ok;
    logic [ssd_pkg::PAIR_W-1:0] r_pidx, r_pfree;
    logic                      r_rmatch, r_rfree_ok;
    logic [ssd_pkg::REQ_W-1:0]  r_ridx, r_rfree;

    // Report selection and counting.
    logic                      r_have_prev, r_found;
    logic [63:0]               r_prev, r_best_key;
    logic [ssd_pkg::PAIR_W-1:0] r_best_idx;
    logic [ssd_pkg::CNT_W-1:0]  r_una, r_ans;
    logic                      r_pend;
    logic [63:0]               r_pend_key;
    logic [ssd_pkg::CNT_W-1:0]  r_pend_una, r_pend_ans;
    logic [ssd_pkg::NRES_W-1:0] r_nres;

    // Request memory port.
    logic                      w_we;
    logic [ssd_pkg::REQ_W-1:0]  w_waddr;
    ssd_pkg::t_req_word        w_wdata;
    ssd_pkg::t_req_word        w_rdata;

    logic [ssd_pkg::PAIR_W-1:0] w_pi;
    logic [ssd_pkg::REQ_W-1:0]  w_ci;
    logic                      w_plast, w_rdone, w_chk, w_take, w_flag;
    logic [10:0]               w_prod;
    logic [63:0]               w_pkey;

    assign w_pi    = r_cnt[ssd_pkg::PAIR_W-1:0];
    assign w_ci    = ssd_pkg::REQ_W'(r_cnt - 1'b1);
    assign w_plast = (r_cnt == ssd_pkg::RCNT_W'(ssd_pkg::PAIR_SLOTS - 1));
    assign w_rdone = (r_cnt == ssd_pkg::RCNT_W'(ssd_pkg::REQ_SLOTS));
    assign w_chk   = (r_cnt != '0);
    assign w_pkey  = r_pair_key[w_pi];
    assign busy    = (r_state != ssd_pkg::ST_IDLE);
    assign o_cfg_ready = 1'b1;

    // Report selection: smallest valid key above the last one taken.
    assign w_take = r_pair_valid[w_pi] && (!r_have_prev || w_pkey > r_prev) &&
                    (!r_found || w_pkey < r_best_key);

    // Flag test, ratio times answered against unanswered.
    assign w_prod = 11'(r_ratio) * 11'(r_ans);
    assign w_flag = (r_ans == '0) || (11'(r_una) >= w_prod);

    ssd_req_ram u_req_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (r_cnt[ssd_pkg::REQ_W-1:0]),
        .o_rdata (w_rdata)
    );

    // Write of the request memory at the end of a packet.
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_rfree;
        w_wdata.owner    = r_pfound ? r_pidx : r_pfree;
        w_wdata.ports    = r_ports;
        w_wdata.seq      = r_seq;
        w_wdata.answered = 1'b0;
        if (r_state == ssd_pkg::ST_WRITE) begin
            if (r_pfound && r_rmatch) begin
                w_we    = 1'b1;
                w_waddr = r_ridx;
                w_wdata.answered = r_is_ack;
            end else if (!r_is_ack && r_rfree_ok && (r_pfound || r_pfree_ok)) begin
                w_we = 1'b1;
            end
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ssd_pkg::ST_IDLE: begin
                if (start && i_command) begin
                    n_state = ssd_pkg::ST_RSEL;
                end else if (start && i_syn_flag) begin
                    n_state = ssd_pkg::ST_PSCAN;
                end
            end
            ssd_pkg::ST_PSCAN: begin
                if (w_plast) n_state = ssd_pkg::ST_RSCAN;
            end
            ssd_pkg::ST_RSCAN: begin
                if (w_rdone) n_state = r_rep ? ssd_pkg::ST_REVAL : ssd_pkg::ST_WRITE;
            end
            ssd_pkg::ST_WRITE: n_state = ssd_pkg::ST_IDLE;
            ssd_pkg::ST_RSEL: begin
                if (w_plast) begin
                    n_state = (r_found || w_take) ? ssd_pkg::ST_RSCAN : ssd_pkg::ST_RFIN;
                end
            end
            ssd_pkg::ST_REVAL: n_state = ssd_pkg::ST_RSEL;
            ssd_pkg::ST_RFIN:  n_state = ssd_pkg::ST_IDLE;
            default:           n_state = ssd_pkg::ST_IDLE;
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ssd_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Pair table keys carry no reset.
    always_ff @(posedge i_clk) begin
        if (r_state == ssd_pkg::ST_WRITE && !r_is_ack && !r_pfound && r_pfree_ok &&
            r_rfree_ok && !r_rmatch) begin
            r_pair_key[r_pfree] <= r_key;
        end
    end

    // Datapath of the sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ratio      <= ssd_pkg::RATIO_RESET;
            r_pair_valid <= '0;
            r_req_valid  <= '0;
            r_ovf        <= 1'b0;
            o_valid      <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            if (i_cfg_valid) begin
                r_ratio <= i_cfg_warning_ratio;
            end
            unique case (r_state)
                ssd_pkg::ST_IDLE: begin
                    r_cnt       <= '0;
                    r_rep       <= i_command;
                    r_is_ack    <= i_ack_flag;
                    r_pfound    <= 1'b0;
                    r_pfree_ok  <= 1'b0;
                    r_have_prev <= 1'b0;
                    r_found     <= 1'b0;
                    r_pend      <= 1'b0;
                    r_nres      <= '0;
                    if (i_ack_flag) begin
                        r_key   <= {i_dst_addr, i_src_addr};
                        r_ports <= {i_dst_port, i_src_port};
                        r_seq   <= i_ack_num - 32'd1;
                    end else begin
                        r_key   <= {i_src_addr, i_dst_addr};
                        r_ports <= {i_src_port, i_dst_port};
                        r_seq   <= i_seq_num;
                    end
                end
                ssd_pkg::ST_PSCAN: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_pair_valid[w_pi] && w_pkey == r_key && !r_pfound) begin
                        r_pfound <= 1'b1;
                        r_pidx   <= w_pi;
                    end
                    if (!r_pair_valid[w_pi] && !r_pfree_ok) begin
                        r_pfree_ok <= 1'b1;
                        r_pfree    <= w_pi;
                    end
                    if (w_plast) begin
                        r_cnt      <= '0;
                        r_rmatch   <= 1'b0;
                        r_rfree_ok <= 1'b0;
                    end
                end
                ssd_pkg::ST_RSCAN: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (w_chk && r_rep) begin
                        // Count the requests of the selected pair.
                        if (r_req_valid[w_ci] && w_rdata.owner == r_best_idx) begin
                            if (w_rdata.answered) r_ans <= r_ans + 1'b1;
                            else                  r_una <= r_una + 1'b1;
                        end
                    end else if (w_chk) begin
                        // First matching request and first free slot.
                        if (r_pfound && r_req_valid[w_ci] && !r_rmatch &&
                            w_rdata.owner == r_pidx && w_rdata.ports == r_ports &&
                            w_rdata.seq == r_seq) begin
                            r_rmatch <= 1'b1;
                            r_ridx   <= w_ci;
                        end
                        if (!r_req_valid[w_ci] && !r_rfree_ok) begin
                            r_rfree_ok <= 1'b1;
                            r_rfree    <= w_ci;
                        end
                    end
                end
                ssd_pkg::ST_WRITE: begin
                    if (!(r_pfound && r_rmatch) && !r_is_ack) begin
                        if (r_rfree_ok && (r_pfound || r_pfree_ok)) begin
                            r_req_valid[r_rfree] <= 1'b1;
                            if (!r_pfound) r_pair_valid[r_pfree] <= 1'b1;
                        end else begin
                            r_ovf <= 1'b1;
                        end
                    end
                end
                ssd_pkg::ST_RSEL: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (w_take) begin
                        r_found    <= 1'b1;
                        r_best_key <= w_pkey;
                        r_best_idx <= w_pi;
                    end
                    if (w_plast) begin
                        r_cnt <= '0;
                        r_una <= '0;
                        r_ans <= '0;
                    end
                end
                ssd_pkg::ST_REVAL: begin
                    r_cnt       <= '0;
                    r_prev      <= r_best_key;
                    r_have_prev <= 1'b1;
                    r_found     <= 1'b0;
                    if (w_flag && r_nres != ssd_pkg::NRES_W'(ssd_pkg::MAX_RESULTS)) begin
                        // Hold this word back until the next one shows whether it is last.
                        if (r_pend) begin
                            o_valid            <= 1'b1;
                            o_pair_src         <= r_pend_key[63:32];
                            o_pair_dst         <= r_pend_key[31:0];
                            o_unanswered_count <= r_pend_una;
                            o_answered_count   <= r_pend_ans;
                            o_none_flagged     <= 1'b0;
                            o_table_overflow   <= r_ovf;
                            o_last             <= 1'b0;
                        end
                        r_pend     <= 1'b1;
                        r_pend_key <= r_best_key;
                        r_pend_una <= r_una;
                        r_pend_ans <= r_ans;
                        r_nres     <= r_nres + 1'b1;
                    end
                end
                ssd_pkg::ST_RFIN: begin
                    o_valid          <= 1'b1;
                    o_table_overflow <= r_ovf;
                    o_last           <= 1'b1;
                    o_none_flagged   <= !r_pend;
                    if (r_pend) begin
                        o_pair_src         <= r_pend_key[63:32];
                        o_pair_dst         <= r_pend_key[31:0];
                        o_unanswered_count <= r_pend_una;
                        o_answered_count   <= r_pend_ans;
                    end else begin
                        o_pair_src         <= '0;
                        o_pair_dst         <= '0;
                        o_unanswered_count <= '0;
                        o_answered_count   <= '0;
                    end
                    r_pair_valid <= '0;
                    r_req_valid  <= '0;
                    r_ovf        <= 1'b0;
                end
                default: ;
            endcase
        end
    end

`ifndef SYNTHESIS
    // Result words come only from the report steps.
    a_out_from_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($past(r_state) == ssd_pkg::ST_REVAL ||
                     $past(r_state) == ssd_pkg::ST_RFIN))
        else $error("result word outside a report");

    // The empty report word is the last one and carries no pair.
    a_none_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_none_flagged) |-> (o_last && o_pair_src == '0 &&
                                         o_answered_count == '0))
        else $error("malformed empty report word");

    // A finished report leaves all tables empty.
    a_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ssd_pkg::ST_RFIN) |=> (r_pair_valid == '0 && r_req_valid == '0 && !r_ovf))
        else $error("tables not cleared after report");
`endif

endmodule

// ----- design/ssd_req_ram.sv -----
// Request table storage: one write port, one registered read port.
// Depends on ssd_pkg for depth and word type.
module ssd_req_ram (
    input  logic                    i_clk,
    input  logic                    i_we,
    input  logic [ssd_pkg::REQ_W-1:0] i_waddr,
    input  ssd_pkg::t_req_word      i_wdata,
    input  logic [ssd_pkg::REQ_W-1:0] i_raddr,
    output ssd_pkg::t_req_word      o_rdata
);

    ssd_pkg::t_req_word r_mem [ssd_pkg::REQ_SLOTS];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for syn_scan_detector_core. It predicts every report
// word from its own copy of the pair and request tables. Depends on ssd_pkg.
module tb;

    localparam logic CMD_OBSERVE = 1'b0;
    localparam logic CMD_REPORT  = 1'b1;
    localparam int   CYCLE_LIMIT = 1000000;
    localparam int   DRAIN_WAIT  = 120;

    typedef struct {
        logic        command;
        logic [31:0] src_addr, dst_addr, seq_num, ack_num;
        logic [15:0] src_port, dst_port;
        logic        syn_flag, ack_flag;
    } t_packet;

    typedef struct {
        logic [31:0] pair_src, pair_dst;
        logic [6:0]  unanswered, answered;
        logic        none_flagged, overflow, last;
    } t_flag_word;

    logic        i_clk = 1'b0, i_rst_n = 1'b0, start = 1'b0, busy;
    logic        i_command = 1'b0, i_syn_flag = 1'b0, i_ack_flag = 1'b0;
    logic [31:0] i_src_addr = '0, i_dst_addr = '0, i_seq_num = '0, i_ack_num = '0;
    logic [15:0] i_src_port = '0, i_dst_port = '0;
    logic        i_cfg_valid = 1'b0, o_cfg_ready;
    logic [3:0]  i_cfg_warning_ratio = '0;
    logic        o_valid, o_none_flagged, o_table_overflow, o_last;
    logic [31:0] o_pair_src, o_pair_dst;
    logic [6:0]  o_unanswered_count, o_answered_count;

    syn_scan_detector_core u_dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Predicted detector state.
    logic [3:0]  ratio_q = ssd_pkg::RATIO_RESET;
    logic        pair_used [ssd_pkg::PAIR_SLOTS];
    logic [63:0] pair_addr [ssd_pkg::PAIR_SLOTS];
    logic        req_used [ssd_pkg::REQ_SLOTS];
    int          req_pair [ssd_pkg::REQ_SLOTS];
    logic [31:0] req_ports [ssd_pkg::REQ_SLOTS];
    logic [31:0] req_seq [ssd_pkg::REQ_SLOTS];
    logic        req_acked [ssd_pkg::REQ_SLOTS];
    logic        dropped_seen;

    t_packet     pending_packets[$];
    t_flag_word  flagged_words[$];
    int          mismatches = 0;
    int          sender_idle_pct = 0;
    int          cycles = 0;
    logic        handed = 1'b0, cfg_taken = 1'b0;

    function automatic void clear_tables();
        for (int i = 0; i < ssd_pkg::PAIR_SLOTS; i++) pair_used[i] = 1'b0;
        for (int i = 0; i < ssd_pkg::REQ_SLOTS; i++) req_used[i] = 1'b0;
        dropped_seen = 1'b0;
    endfunction

    function automatic int lookup_pair(logic [63:0] key);
        for (int i = 0; i < ssd_pkg::PAIR_SLOTS; i++)
            if (pair_used[i] && pair_addr[i] == key) return i;
        return -1;
    endfunction

    function automatic int lookup_request(int p, logic [31:0] ports, logic [31:0] sq);
        for (int i = 0; i < ssd_pkg::REQ_SLOTS; i++)
            if (req_used[i] && req_pair[i] == p && req_ports[i] == ports && req_seq[i] == sq)
                return i;
        return -1;
    endfunction

    // Record a connection request, reusing an identical one if present.
    function automatic void record_syn(logic [63:0] key, logic [31:0] ports, logic [31:0] sq);
        int p, r, free_p, free_r;
        p = lookup_pair(key);
        free_p = -1;
        free_r = -1;
        if (p >= 0) begin
            r = lookup_request(p, ports, sq);
            if (r >= 0) begin
                req_acked[r] = 1'b0;
                return;
            end
        end
        for (int i = ssd_pkg::REQ_SLOTS - 1; i >= 0; i--) if (!req_used[i]) free_r = i;
        for (int i = ssd_pkg::PAIR_SLOTS - 1; i >= 0; i--) if (!pair_used[i]) free_p = i;
        if (free_r < 0 || (p < 0 && free_p < 0)) begin
            dropped_seen = 1'b1;
            return;
        end
        if (p < 0) begin
            p = free_p;
            pair_used[p] = 1'b1;
            pair_addr[p] = key;
        end
        req_used[free_r] = 1'b1;
        req_pair[free_r] = p;
        req_ports[free_r] = ports;
        req_seq[free_r] = sq;
        req_acked[free_r] = 1'b0;
    endfunction

    // Build the report words in ascending pair order, then clear the tables.
    function automatic void build_report();
        int order[$];
        int una, ans, count;
        t_flag_word w;
        for (int i = 0; i < ssd_pkg::PAIR_SLOTS; i++) if (pair_used[i]) order.push_back(i);
        order.sort() with (pair_addr[item]);
        count = 0;
        foreach (order[k]) begin
            una = 0;
            ans = 0;
            for (int r = 0; r < ssd_pkg::REQ_SLOTS; r++)
                if (req_used[r] && req_pair[r] == order[k]) begin
                    if (req_acked[r]) ans++;
                    else una++;
                end
            if (count < ssd_pkg::MAX_RESULTS && (ans == 0 || una >= int'(ratio_q) * ans)) begin
                w = '{default: '0};
                w.pair_src = pair_addr[order[k]][63:32];
                w.pair_dst = pair_addr[order[k]][31:0];
                w.unanswered = una[6:0];
                w.answered = ans[6:0];
                w.overflow = dropped_seen;
                flagged_words.push_back(w);
                count++;
            end
        end
        // A report with no flagged pair still gives one word.
        if (count == 0) begin
            w = '{default: '0};
            w.overflow = dropped_seen;
            w.none_flagged = 1'b1;
            flagged_words.push_back(w);
        end
        flagged_words[$].last = 1'b1;
        clear_tables();
    endfunction

    function automatic void predict(t_packet t);
        if (t.command == CMD_REPORT) build_report();
        else if (t.syn_flag && t.ack_flag)
            begin
                int p, r;
                p = lookup_pair({t.dst_addr, t.src_addr});
                if (p >= 0) begin
                    r = lookup_request(p, {t.dst_port, t.src_port}, t.ack_num - 32'd1);
                    if (r >= 0) req_acked[r] = 1'b1;
                end
            end
        else if (t.syn_flag)
            record_syn({t.src_addr, t.dst_addr}, {t.src_port, t.dst_port}, t.seq_num);
    endfunction

    // Driver: a new word goes out, at the earliest, at the falling edge after the last one was taken.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!start || handed) begin
            if (pending_packets.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
                t_packet t;
                t = pending_packets.pop_front();
                i_command <= t.command;
                i_src_addr <= t.src_addr;
                i_dst_addr <= t.dst_addr;
                i_src_port <= t.src_port;
                i_dst_port <= t.dst_port;
                i_seq_num <= t.seq_num;
                i_ack_num <= t.ack_num;
                i_syn_flag <= t.syn_flag;
                i_ack_flag <= t.ack_flag;
                start <= 1'b1;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Acceptance, prediction, configuration tracking and result checking.
    always @(posedge i_clk) begin
        t_packet    t;
        t_flag_word w;
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        handed <= i_rst_n && start && !busy;
        cfg_taken <= i_rst_n && i_cfg_valid && o_cfg_ready;
        if (!i_rst_n) begin
            ratio_q <= ssd_pkg::RATIO_RESET;
            clear_tables();
        end else begin
            if (i_cfg_valid && o_cfg_ready) ratio_q <= i_cfg_warning_ratio;
            if (start && !busy) begin
                t = '{i_command, i_src_addr, i_dst_addr, i_seq_num, i_ack_num,
                      i_src_port, i_dst_port, i_syn_flag, i_ack_flag};
                predict(t);
            end
            if (o_valid) begin
                if (flagged_words.size() == 0) begin
                    $error("unexpected report word src=%h dst=%h", o_pair_src, o_pair_dst);
                    mismatches++;
                end else begin
                    w = flagged_words.pop_front();
                    if (o_pair_src !== w.pair_src) begin
                        $error("pair_src expected %h got %h", w.pair_src, o_pair_src);
                        mismatches++;
                    end
                    if (o_pair_dst !== w.pair_dst) begin
                        $error("pair_dst expected %h got %h", w.pair_dst, o_pair_dst);
                        mismatches++;
                    end
                    if (o_unanswered_count !== w.unanswered) begin
                        $error("unanswered_count expected %0d got %0d", w.unanswered,
                               o_unanswered_count);
                        mismatches++;
                    end
                    if (o_answered_count !== w.answered) begin
                        $error("answered_count expected %0d got %0d", w.answered,
                               o_answered_count);
                        mismatches++;
                    end
                    if (o_none_flagged !== w.none_flagged) begin
                        $error("none_flagged expected %b got %b", w.none_flagged,
                               o_none_flagged);
                        mismatches++;
                    end
                    if (o_table_overflow !== w.overflow) begin
                        $error("table_overflow expected %b got %b", w.overflow,
                               o_table_overflow);
                        mismatches++;
                    end
                    if (o_last !== w.last) begin
                        $error("last expected %b got %b", w.last, o_last);
                        mismatches++;
                    end
                end
            end
        end
    end

    function automatic t_packet make_packet(logic cmd, logic [31:0] sa, logic [31:0] da,
                                            logic [15:0] sp, logic [15:0] dp,
                                            logic [31:0] sq, logic [31:0] ak,
                                            logic syn, logic ack);
        t_packet t;
        t = '{cmd, sa, da, sq, ak, sp, dp, syn, ack};
        return t;
    endfunction

    function automatic t_packet noise_packet();
        return make_packet(CMD_OBSERVE, $urandom, $urandom, 16'($urandom), 16'($urandom),
                           $urandom, $urandom, 1'($urandom_range(1)),
                           1'($urandom_range(1)));
    endfunction

    // A session of packets over a small address pool, closed by a report.
    task automatic add_session(int n);
        t_packet sent[$];
        t_packet t, s;
        logic [31:0] src_pool[6] = '{32'h0A000001, 32'h0A000002, 32'hC0A80001,
                                     32'hFFFFFFFE, 32'h00000000, 32'h7F000001};
        logic [31:0] dst_pool[4] = '{32'hC0A80010, 32'h08080808, 32'hFFFFFFFF, 32'h0A000001};
        int pick;
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(99);
            if (pick < 45 || sent.size() == 0) begin
                t = make_packet(CMD_OBSERVE, src_pool[$urandom_range(5)],
                                dst_pool[$urandom_range(3)], 16'($urandom_range(1023, 1020)),
                                16'($urandom_range(81, 79)), $urandom_range(7), $urandom,
                                1'b1, 1'b0);
                if ($urandom_range(3) == 0) t.seq_num = $urandom;
                sent.push_back(t);
            end else if (pick < 82) begin
                // Answer or re-send an earlier request of this session.
                s = sent[$urandom_range(sent.size() - 1)];
                if ($urandom_range(5) == 0) t = s;
                else t = make_packet(CMD_OBSERVE, s.dst_addr, s.src_addr, s.dst_port,
                                     s.src_port, $urandom, s.seq_num + 32'd1, 1'b1, 1'b1);
            end else if (pick < 92) begin
                t = noise_packet();
            end else begin
                t = make_packet(CMD_OBSERVE, dst_pool[$urandom_range(3)],
                                src_pool[$urandom_range(5)], 16'($urandom), 16'($urandom),
                                $urandom, $urandom_range(8), 1'b1, 1'b1);
            end
            pending_packets.push_back(t);
        end
        pending_packets.push_back(make_packet(CMD_REPORT, $urandom, $urandom, 16'($urandom),
                                              16'($urandom), $urandom, $urandom,
                                              1'($urandom_range(1)),
                                              1'($urandom_range(1))));
    endtask

    task automatic wait_idle();
        do @(posedge i_clk);
        while (pending_packets.size() != 0 || start || busy || flagged_words.size() != 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_ratio(logic [3:0] r);
        @(negedge i_clk);
        i_cfg_warning_ratio <= r;
        i_cfg_valid <= 1'b1;
        do @(negedge i_clk);
        while (!cfg_taken);
        i_cfg_valid <= 1'b0;
    endtask

    // Stimulus: directed cases first, then random sessions over several phases.
    initial begin
        int phase_idle[4] = '{0, 88, 0, 20};
        logic [3:0] phase_ratio[4] = '{4'd15, 4'd0, 4'd1, 4'd3};
        int queued;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        pending_packets.push_back(make_packet(CMD_OBSERVE, '1, '1, '1, '1, '1, '1, 1'b1, 1'b0));
        // Answer it with an acknowledgment of zero, which wraps back to the all-ones sequence.
        pending_packets.push_back(make_packet(CMD_OBSERVE, '1, '1, '1, '1, '0, '0, 1'b1, 1'b1));
        pending_packets.push_back(make_packet(CMD_OBSERVE, '1, '1, '1, '1, '1, '1, 1'b1, 1'b0));
        pending_packets.push_back(make_packet(CMD_OBSERVE, '0, '0, '0, '0, '0, '0, 1'b1, 1'b0));
        // SYN/ACK for a pair that was never seen, then one with wrong ports.
        pending_packets.push_back(make_packet(CMD_OBSERVE, 32'h1, 32'h2, 16'h3, 16'h4,
                                              '0, 32'h1, 1'b1, 1'b1));
        pending_packets.push_back(make_packet(CMD_OBSERVE, '0, '0, 16'h5, '0, '0, 32'h1,
                                              1'b1, 1'b1));
        pending_packets.push_back(make_packet(CMD_OBSERVE, '0, '0, '0, '0, '0, '0, 1'b0, 1'b1));
        pending_packets.push_back(make_packet(CMD_OBSERVE, '1, '0, '1, '0, '1, '0, 1'b0, 1'b0));
        pending_packets.push_back(make_packet(CMD_REPORT, '0, '0, '0, '0, '0, '0, 1'b0, 1'b0));
        pending_packets.push_back(make_packet(CMD_REPORT, '1, '1, '1, '1, '1, '1, 1'b1, 1'b1));
        // One more distinct pair than the pair table holds.
        for (int i = 0; i <= ssd_pkg::PAIR_SLOTS; i++)
            pending_packets.push_back(make_packet(CMD_OBSERVE, 32'h0B000000 + i,
                                                  32'hC0000000 - i, 16'd4000, 16'd22,
                                                  i, '0, 1'b1, 1'b0));
        pending_packets.push_back(make_packet(CMD_REPORT, '0, '0, '0, '0, '0, '0, 1'b0, 1'b0));
        // One more request than the request table holds, all on one pair.
        for (int i = 0; i <= ssd_pkg::REQ_SLOTS; i++)
            pending_packets.push_back(make_packet(CMD_OBSERVE, 32'h0C000001, 32'h0D000001,
                                                  16'd5000, 16'd80, i, '0, 1'b1, 1'b0));
        pending_packets.push_back(make_packet(CMD_REPORT, '0, '0, '0, '0, '0, '0, 1'b0, 1'b0));

        for (int ph = 0; ph < 4; ph++) begin
            wait_idle();
            write_ratio(phase_ratio[ph]);
            sender_idle_pct = phase_idle[ph];
            queued = 0;
            while (queued < 16) begin
                int n;
                n = ($urandom_range(3) == 0) ? $urandom_range(24, 14) : $urandom_range(10, 3);
                add_session(n);
                queued += n + 1;
            end
        end
        wait_idle();

        if (mismatches == 0) $display("SCOREBOARD CLEAN");
        else $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ----- files.f -----
design/ssd_pkg.sv
design/ssd_req_ram.sv
design/syn_scan_detector_core.sv
tb/sv/tb.sv
